// File: rtl/core/msq_pkg.sv
// shared types, codes and song tables for the melody sequencer
package msq_pkg;

  localparam int SONG_COUNT = 4;
  localparam int MAX_NOTES  = 32;
  localparam int SONG_W     = 2;
  localparam int POS_W      = $clog2(MAX_NOTES);
  localparam int FREQ_W     = 10;
  localparam int LEN_W      = 11;
  localparam int SHIFT_W    = 3;

  // shared multiplier operand widths
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // wait = floor(len*105/100), divide by 100 through 2^24 reciprocal
  localparam logic [MUL_B_W-1:0] WAIT_SCALE  = MUL_B_W'(105);
  localparam int                 RECIP_SHIFT = 24;
  localparam logic [MUL_B_W-1:0] RECIP_100   = MUL_B_W'((2**RECIP_SHIFT) / 100 + 1);

  localparam logic [10:0] FRAME_ID_CMD = 11'd1;

  localparam logic [7:0] CMD_LAMP_ON    = 8'd40;
  localparam logic [7:0] CMD_LAMP_OFF   = 8'd41;
  localparam logic [7:0] CMD_SONG_FIRST = 8'd60;
  localparam logic [7:0] CMD_SONG_LAST  = 8'd63;
  localparam logic [7:0] CMD_PAUSE      = 8'd66;
  localparam logic [7:0] CMD_STOP       = 8'd99;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_SILENCE = 2'd2
  } tone_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL1,
    ST_MUL2,
    ST_SCALE,
    ST_DONE
  } msq_state_t;

  // song length in elements
  localparam logic [POS_W-1:0] SONG_LEN [SONG_COUNT] = '{
    POS_W'(24), POS_W'(26), POS_W'(21), POS_W'(16)
  };

  // 100 * tempo in tenths, i.e. length of a whole note in ms
  localparam logic [LEN_W-1:0] TEMPO_X100 [SONG_COUNT] = '{
    LEN_W'(1000), LEN_W'(900), LEN_W'(1200), LEN_W'(800)
  };

  // note frequencies, 0 marks a rest
  localparam logic [FREQ_W-1:0] ROM_FREQ [SONG_COUNT][MAX_NOTES] = '{
    '{10'd277, 10'd554, 10'd415, 10'd370, 10'd370, 10'd415, 10'd698, 10'd415,
      10'd277, 10'd554, 10'd415, 10'd370, 10'd370, 10'd415, 10'd698, 10'd415,
      10'd247, 10'd554, 10'd415, 10'd370, 10'd370, 10'd415, 10'd698, 10'd415,
      10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
    '{10'd740, 10'd740, 10'd587, 10'd494, 10'd0,   10'd494, 10'd0,   10'd659,
      10'd659, 10'd659, 10'd831, 10'd831, 10'd880, 10'd988, 10'd880, 10'd880,
      10'd880, 10'd659, 10'd587, 10'd740, 10'd740, 10'd740, 10'd659, 10'd659,
      10'd740, 10'd659, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
    '{10'd311, 10'd330, 10'd0,   10'd370, 10'd392, 10'd0,   10'd311, 10'd330,
      10'd370, 10'd392, 10'd523, 10'd494, 10'd330, 10'd392, 10'd494, 10'd466,
      10'd440, 10'd392, 10'd330, 10'd294, 10'd330, 10'd0,   10'd0,   10'd0,
      10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
    '{10'd131, 10'd131, 10'd156, 10'd131, 10'd196, 10'd185, 10'd175, 10'd156,
      10'd131, 10'd131, 10'd156, 10'd131, 10'd233, 10'd220, 10'd208, 10'd196,
      10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
      10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0}
  };

  // duration codes 1, 2, 4, 8, 16 stored as their log2
  localparam logic [SHIFT_W-1:0] ROM_SHIFT [SONG_COUNT][MAX_NOTES] = '{
    '{3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd3, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd1, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

endpackage

// File: rtl/core/command_driven_melody_sequencer.sv
// melody sequencer top level: command decode, note timing and result register
//
//  channel  direction  handshake              payload
//  in       to block   in_valid / in_stall    operation, frame_id, command_byte
//  out      from block out_valid / out_stall  tone_action, tone_frequency,
//                                             tone_length_ms, brake_light,
//                                             is_playing, is_paused
//
// one item at a time; in_stall is high from acceptance until the result is written
// commands and ticks that reach no note boundary go straight from idle to done, a rest or
// the wrap past the last element passes through fetch, a note through fetch, mul1, mul2, scale:
//   the note wait floor(len*105/100) runs twice through one shared 17x18 multiplier
// the result sits in an output register, so a new item is taken while it waits
// a stalled output holds the sequencer in its last state until the register frees
// rst is synchronous, clears all song state, lamp and output valid
module command_driven_melody_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [10:0] frame_id,
  input  logic [7:0]  command_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  tone_action,
  output logic [msq_pkg::FREQ_W-1:0] tone_frequency,
  output logic [msq_pkg::LEN_W-1:0]  tone_length_ms,
  output logic        brake_light,
  output logic        is_playing,
  output logic        is_paused
);
  import msq_pkg::*;

  msq_state_t state, state_next;

  // song state
  logic              lamp_on, lamp_on_next;
  logic              playing, playing_next;
  logic              paused, paused_next;
  logic [SONG_W-1:0] song_select, song_select_next;
  logic [POS_W-1:0]  note_position, note_position_next;
  logic [LEN_W-1:0]  wait_left, wait_left_next;

  // result under construction; res_len doubles as the note length operand
  tone_action_t      res_action, res_action_next;
  logic [FREQ_W-1:0] res_freq, res_freq_next;
  logic [LEN_W-1:0]  res_len, res_len_next;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_prod;
  logic [PROD_W-1:0]  product, product_next;

  // output register
  logic               out_valid_next;
  logic               out_load;

  logic               in_accept;
  logic [LEN_W-1:0]   wait_dec;
  logic [SONG_W-1:0]  cmd_song;
  logic [FREQ_W-1:0]  rom_freq;
  logic [LEN_W-1:0]   rom_dur;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // tick countdown, saturating at zero
  assign wait_dec = (wait_left != '0) ? wait_left - LEN_W'(1) : wait_left;

  assign cmd_song = SONG_W'(command_byte - CMD_SONG_FIRST);

  // element lookup; duration codes are powers of two, so the divide is a shift
  assign rom_freq = ROM_FREQ[song_select][note_position];
  assign rom_dur  = TEMPO_X100[song_select] >> ROM_SHIFT[song_select][note_position];

  assign mul_prod = {{(PROD_W-MUL_A_W){1'b0}}, mul_a} * {{(PROD_W-MUL_B_W){1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    lamp_on_next       = lamp_on;
    playing_next       = playing;
    paused_next        = paused;
    song_select_next   = song_select;
    note_position_next = note_position;
    wait_left_next     = wait_left;
    res_action_next    = res_action;
    res_freq_next      = res_freq;
    res_len_next       = res_len;
    product_next       = product;
    mul_a              = '0;
    mul_b              = '0;
    out_load           = 1'b0;
    out_valid_next     = out_valid && out_stall;

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          res_action_next = ACT_NONE;
          res_freq_next   = '0;
          res_len_next    = '0;
          state_next      = ST_DONE;
          if (operation) begin
            // command frame, other identifiers are ignored
            if (frame_id == FRAME_ID_CMD) begin
              unique case (command_byte) inside
                CMD_LAMP_ON: lamp_on_next = 1'b1;
                CMD_LAMP_OFF: lamp_on_next = 1'b0;
                CMD_STOP: begin
                  playing_next    = 1'b0;
                  paused_next     = 1'b0;
                  res_action_next = ACT_SILENCE;
                end
                [CMD_SONG_FIRST:CMD_SONG_LAST]: begin
                  if (int'(cmd_song) < SONG_COUNT) begin
                    song_select_next   = cmd_song;
                    playing_next       = 1'b1;
                    paused_next        = 1'b0;
                    note_position_next = '0;
                    wait_left_next     = '0;
                    res_action_next    = ACT_SILENCE;
                  end
                end
                CMD_PAUSE: begin
                  if (playing) begin
                    paused_next = !paused;
                    if (!paused) begin
                      res_action_next = ACT_SILENCE;
                    end else begin
                      // resume acts on the next tick
                      wait_left_next = '0;
                    end
                  end
                end
                default: ;
              endcase
            end
          end else if (playing && !paused) begin
            wait_left_next = wait_dec;
            if (wait_dec == '0) begin
              state_next = ST_FETCH;
            end
          end
        end
      end
      ST_FETCH: begin
        if (note_position < SONG_LEN[song_select]) begin
          note_position_next = note_position + POS_W'(1);
          if (rom_freq == '0) begin
            res_action_next = ACT_SILENCE;
            wait_left_next  = rom_dur;
            state_next      = ST_DONE;
          end else begin
            res_action_next = ACT_START;
            res_freq_next   = rom_freq;
            res_len_next    = rom_dur;
            state_next      = ST_MUL1;
          end
        end else begin
          // past the last element, wrap silently
          note_position_next = '0;
          state_next         = ST_DONE;
        end
      end
      ST_MUL1: begin
        mul_a        = MUL_A_W'(res_len);
        mul_b        = WAIT_SCALE;
        product_next = mul_prod;
        state_next   = ST_MUL2;
      end
      ST_MUL2: begin
        mul_a        = product[MUL_A_W-1:0];
        mul_b        = RECIP_100;
        product_next = mul_prod;
        state_next   = ST_SCALE;
      end
      ST_SCALE: begin
        wait_left_next = product[RECIP_SHIFT +: LEN_W];
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control and song state
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_on       <= 1'b0;
      playing       <= 1'b0;
      paused        <= 1'b0;
      song_select   <= '0;
      note_position <= '0;
      wait_left     <= '0;
      out_valid     <= 1'b0;
    end else begin
      lamp_on       <= lamp_on_next;
      playing       <= playing_next;
      paused        <= paused_next;
      song_select   <= song_select_next;
      note_position <= note_position_next;
      wait_left     <= wait_left_next;
      out_valid     <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_action <= res_action_next;
    res_freq   <= res_freq_next;
    res_len    <= res_len_next;
    product    <= product_next;
    if (out_load) begin
      tone_action    <= res_action;
      tone_frequency <= res_freq;
      tone_length_ms <= res_len;
      brake_light    <= lamp_on;
      is_playing     <= playing;
      is_paused      <= paused;
    end
  end

  // pause only exists inside an active song
  assert property (@(posedge clk) disable iff (rst) paused |-> playing)
    else $error("paused without an active song");

  // position never runs beyond the selected song
  assert property (@(posedge clk) disable iff (rst)
    note_position <= SONG_LEN[song_select])
    else $error("note position beyond song length");

  // a started tone always carries a pitch and a length
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (tone_action == ACT_START) |-> (tone_frequency != '0) && (tone_length_ms != '0))
    else $error("tone start without frequency or length");

  // the multiplier chain ends with a wait at least as long as the tone
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE) |=> (wait_left >= res_len))
    else $error("note wait shorter than note length");

endmodule
